/* sv/coalescing_sound_event_queue_defines.svh */
// ----------------------------------------------------------------------------
// coalescing_sound_event_queue_defines
// Assertion macros shared by the sound event queue modules.
// ----------------------------------------------------------------------------
`ifndef COALESCING_SOUND_EVENT_QUEUE_DEFINES_SVH
`define COALESCING_SOUND_EVENT_QUEUE_DEFINES_SVH

// Checked while out of reset.
`define CSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CSQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/csq_pkg.sv */
// ----------------------------------------------------------------------------
// csq_pkg
// Types and constants of the coalescing sound event queue.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int SND_W   = 8;
    localparam int VOL_W   = 7;
    localparam int COORD_W = 16;
    localparam int ENTRY_W = SND_W + VOL_W;

    // 100*d + range - 1 stays below 2^23 for 16-bit d and range
    localparam int NUM_W  = 23;
    // quotient never exceeds 100 for a heard sound with nonzero range
    localparam int Q_W    = 7;
    localparam int STEP_W = $clog2(Q_W);

    localparam logic [VOL_W-1:0]   VOL_MAX   = 7'd100;
    localparam logic [VOL_W-1:0]   VOL_MIN   = 7'd10;
    localparam logic [Q_W-1:0]     Q_FLOOR   = 7'd90;
    localparam logic [COORD_W-1:0] RANGE_RST = 16'd525;

    typedef enum logic [1:0] {
        KIND_PLAY   = 2'd0,
        KIND_LOCATE = 2'd1,
        KIND_DRAIN  = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_AUDIO_ON = 1'b0,
        CFG_RANGE    = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VOL,
        S_RD,
        S_CMP,
        S_DRD,
        S_DOUT
    } t_state;

    typedef enum logic [2:0] {
        V_IDLE,
        V_MUL,
        V_ADD,
        V_DIV,
        V_DONE
    } t_vstate;

    typedef struct packed {
        logic             done;
        logic             heard;
        logic [VOL_W-1:0] vol;
    } t_vol_res;

endpackage

/* sv/csq_ram.sv */
// ----------------------------------------------------------------------------
// csq_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/csq_vol.sv */
// ----------------------------------------------------------------------------
// csq_vol
// Volume of a located sound: 100 - ceil(100*d/range), floored at 10,
// by a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "coalescing_sound_event_queue_defines.svh"

module csq_vol (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [15:0]           i_dist,
    input  logic [15:0]           i_range,
    output csq_pkg::t_vol_res     o_res
);
    import csq_pkg::*;

    t_vstate             r_vstate, n_vstate;
    logic [COORD_W-1:0]  r_dist, n_dist;
    logic [COORD_W-1:0]  r_range, n_range;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [NUM_W-1:0]    r_div, n_div;
    logic [Q_W-1:0]      r_q, n_q;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_heard, n_heard;
    logic                ge;

    assign ge = (r_num >= r_div);

    // next state
    always_comb begin
        n_vstate = r_vstate;
        unique case (r_vstate)
            V_IDLE: if (i_go) n_vstate = V_MUL;
            V_MUL:  n_vstate = V_ADD;
            V_ADD:  n_vstate = V_DIV;
            V_DIV:  if (r_step == STEP_W'(Q_W - 1)) n_vstate = V_DONE;
            V_DONE: n_vstate = V_IDLE;
            default: n_vstate = V_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_dist  = r_dist;
        n_range = r_range;
        n_num   = r_num;
        n_div   = r_div;
        n_q     = r_q;
        n_step  = r_step;
        n_heard = r_heard;
        unique case (r_vstate)
            V_IDLE: begin
                if (i_go) begin
                    n_dist  = i_dist;
                    n_range = i_range;
                end
            end
            V_MUL: begin
                // 100*d = 64*d + 32*d + 4*d
                n_num   = NUM_W'({r_dist, 6'b0}) + NUM_W'({r_dist, 5'b0})
                        + NUM_W'({r_dist, 2'b0});
                n_heard = (r_dist <= r_range);
            end
            V_ADD: begin
                n_num  = r_num + NUM_W'(r_range) - NUM_W'(1);
                n_div  = NUM_W'(r_range) << (Q_W - 1);
                n_q    = '0;
                n_step = '0;
            end
            V_DIV: begin
                if (ge) begin
                    n_num = r_num - r_div;
                end
                n_q    = {r_q[Q_W-2:0], ge};
                n_div  = r_div >> 1;
                n_step = r_step + STEP_W'(1);
            end
            V_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_res.done  = (r_vstate == V_DONE);
        o_res.heard = r_heard;
        if (r_range == '0) begin
            o_res.vol = VOL_MAX;
        end else if (r_q >= Q_FLOOR) begin
            o_res.vol = VOL_MIN;
        end else begin
            o_res.vol = VOL_MAX - r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vstate <= V_IDLE;
        end else begin
            r_vstate <= n_vstate;
        end
        r_dist  <= n_dist;
        r_range <= n_range;
        r_num   <= n_num;
        r_div   <= n_div;
        r_q     <= n_q;
        r_step  <= n_step;
        r_heard <= n_heard;
    end

    `CSQ_ASSERT(a_vol_bounds, o_res.done |-> (o_res.vol >= VOL_MIN && o_res.vol <= VOL_MAX), "volume out of bounds")
    `CSQ_ASSERT(a_done_pulse, o_res.done |=> !o_res.done, "done held for more than one cycle")
    `CSQ_ASSERT(a_go_starts, (i_go && r_vstate == V_IDLE) |=> r_vstate == V_MUL, "start ignored")

endmodule

/* sv/coalescing_sound_event_queue.sv */
// ----------------------------------------------------------------------------
// coalescing_sound_event_queue
// Per-listener sound queue that merges repeated sounds and drains in order.
// ----------------------------------------------------------------------------
// Sequencing: play reads and compares each queued entry in turn; locate first runs
//   the serial divider; drain alternates a read state and an output state, since the
//   entry RAM read is registered; clear completes from idle.
// Throughput: one command at a time; busy stays high until it finishes.
// Results leave on o_valid and cannot be stalled by the receiver.
// Reset: synchronous, active low; empties the queue, audio off, range 525.
// ----------------------------------------------------------------------------
`include "coalescing_sound_event_queue_defines.svh"

module coalescing_sound_event_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_sound_id,
    input  logic [15:0] i_source_x,
    input  logic [15:0] i_source_y,
    input  logic [15:0] i_listener_x,
    input  logic [15:0] i_listener_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_out_sound,
    output logic [6:0]  o_out_volume,
    output logic        o_last
);
    import csq_pkg::*;

    t_state              r_state, n_state;
    logic [SND_W-1:0]    r_sound, n_sound;
    logic [VOL_W-1:0]    r_vol, n_vol;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_audio;
    logic [COORD_W-1:0]  r_range;

    logic                accept;
    t_kind               kind;
    logic [COORD_W-1:0]  dx, dy, cheb_d;
    logic                vol_go;
    t_vol_res            vol_res;

    logic                ram_we, ram_re;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [SND_W-1:0]    rd_sound;
    logic [VOL_W-1:0]    rd_vol;
    logic                at_end, match, last_out;

    assign accept = start && !busy;
    assign kind   = t_kind'(i_kind);

    assign dx     = (i_source_x >= i_listener_x) ? i_source_x - i_listener_x
                                                 : i_listener_x - i_source_x;
    assign dy     = (i_source_y >= i_listener_y) ? i_source_y - i_listener_y
                                                 : i_listener_y - i_source_y;
    assign cheb_d = (dx > dy) ? dx : dy;

    assign vol_go = accept && (kind == KIND_LOCATE) && r_audio;

    csq_vol u_vol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (vol_go),
        .i_dist  (cheb_d),
        .i_range (r_range),
        .o_res   (vol_res)
    );

    csq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_sound = ram_rdata[ENTRY_W-1:VOL_W];
    assign rd_vol   = ram_rdata[VOL_W-1:0];
    assign at_end   = (r_idx == r_count);
    assign match    = (rd_sound == r_sound);
    assign last_out = ((r_idx + CNT_W'(1)) == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_PLAY:   if (r_audio) n_state = S_RD;
                        KIND_LOCATE: if (r_audio) n_state = S_VOL;
                        KIND_DRAIN:  if (r_count != '0) n_state = S_DRD;
                        KIND_CLEAR:  n_state = S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_VOL:   if (vol_res.done) n_state = vol_res.heard ? S_RD : S_IDLE;
            S_RD:    n_state = at_end ? S_IDLE : S_CMP;
            S_CMP:   n_state = match ? S_IDLE : S_RD;
            S_DRD:   n_state = S_DOUT;
            S_DOUT:  n_state = last_out ? S_IDLE : S_DRD;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        busy         = (r_state != S_IDLE);
        o_cfg_ready  = (r_state == S_IDLE);
        o_valid      = (r_state == S_DOUT);
        o_out_sound  = rd_sound;
        o_out_volume = rd_vol;
        o_last       = last_out;
        ram_re       = (r_state == S_DRD) || (r_state == S_RD && !at_end);
        ram_we       = 1'b0;
        ram_waddr    = r_idx[IDX_W-1:0];
        ram_wdata    = {r_sound, r_vol};
        unique case (r_state)
            // append at the tail when not found and there is room
            S_RD:    ram_we = at_end && (r_count < CNT_W'(QUEUE_DEPTH));
            // merge: keep the louder volume
            S_CMP:   ram_we = match && (rd_vol < r_vol);
            default: ram_we = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_sound = r_sound;
        n_vol   = r_vol;
        n_idx   = r_idx;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_sound = i_sound_id;
                    n_vol   = VOL_MAX;
                    if (kind == KIND_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            S_VOL: begin
                if (vol_res.done) begin
                    n_vol = vol_res.vol;
                end
            end
            S_RD: begin
                if (at_end && (r_count < CNT_W'(QUEUE_DEPTH))) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_CMP: begin
                if (!match) begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_DRD: begin
            end
            S_DOUT: begin
                if (last_out) begin
                    n_count = '0;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_audio <= 1'b0;
            r_range <= RANGE_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_AUDIO_ON: r_audio <= i_cfg_data[0];
                    CFG_RANGE:    r_range <= i_cfg_data;
                    default:      r_audio <= r_audio;
                endcase
            end
        end
        r_sound <= n_sound;
        r_vol   <= n_vol;
        r_idx   <= n_idx;
    end

    `CSQ_ASSERT_ALWAYS(a_count_max, !i_rst_n || r_count <= CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
    `CSQ_ASSERT(a_out_after_read, o_valid |-> $past(r_state == S_DRD), "result without prior read")
    `CSQ_ASSERT(a_last_empties, (o_valid && o_last) |=> r_count == '0, "drain left entries behind")
    `CSQ_ASSERT(a_no_rw_overlap, !(ram_we && ram_re), "entry RAM read and written at once")

endmodule

/* dv/coalescing_sound_event_queue_tb.sv */
// ----------------------------------------------------------------------------
// coalescing_sound_event_queue_tb
// Self-checking bench for the sound event queue. A behavioral copy of the
// queue predicts each drain transfer. Directed tests cover the audio gate,
// the volume curve, the range extremes and a full queue. Random traffic then
// sends request bursts that end in a drain, a clear or neither.
// ----------------------------------------------------------------------------
module coalescing_sound_event_queue_tb;
    import csq_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int TOTAL_ITEMS    = 170;

    typedef struct packed {
        logic [SND_W-1:0] snd;
        logic [VOL_W-1:0] vol;
        logic             last;
    } t_drained;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic [1:0]         i_kind       = KIND_PLAY;
    logic [7:0]         i_sound_id   = '0;
    logic [15:0]        i_source_x   = '0;
    logic [15:0]        i_source_y   = '0;
    logic [15:0]        i_listener_x = '0;
    logic [15:0]        i_listener_y = '0;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index  = CFG_AUDIO_ON;
    logic [15:0]        i_cfg_data   = '0;
    logic               o_valid;
    logic [7:0]         o_out_sound;
    logic [6:0]         o_out_volume;
    logic               o_last;

    // behavioral copy of the queue and its registers
    logic               mdl_audio_on = 1'b0;
    logic [15:0]        mdl_range    = RANGE_RST;
    logic [SND_W-1:0]   mdl_sound  [QUEUE_DEPTH];
    logic [VOL_W-1:0]   mdl_volume [QUEUE_DEPTH];
    int                 mdl_count    = 0;

    t_drained           drain_q[$];
    int                 n_fail          = 0;
    int                 burst_left      = 0;
    int                 sent_items      = 0;
    int                 idle_cycles     = 0;

    coalescing_sound_event_queue i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_sound_id   (i_sound_id),
        .i_source_x   (i_source_x),
        .i_source_y   (i_source_y),
        .i_listener_x (i_listener_x),
        .i_listener_y (i_listener_y),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_out_sound  (o_out_sound),
        .o_out_volume (o_out_volume),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Volume of a located request, or -1 when it is out of hearing range.
    function automatic int located_volume(logic [15:0] sx, logic [15:0] sy,
                                          logic [15:0] lx, logic [15:0] ly);
        int unsigned dx, dy, d, q;
        dx = (sx >= lx) ? sx - lx : lx - sx;
        dy = (sy >= ly) ? sy - ly : ly - sy;
        d  = (dx > dy) ? dx : dy;
        if (d > mdl_range)
            return -1;
        if (mdl_range == 0)
            return VOL_MAX;
        q = (VOL_MAX * d + mdl_range - 1) / mdl_range;
        return (q >= VOL_MAX - VOL_MIN) ? VOL_MIN : VOL_MAX - q;
    endfunction

    function automatic void queue_sound(logic [SND_W-1:0] snd, logic [VOL_W-1:0] vol);
        for (int i = 0; i < mdl_count; i++) begin
            if (mdl_sound[i] == snd) begin
                if (mdl_volume[i] < vol)
                    mdl_volume[i] = vol;
                return;
            end
        end
        if (mdl_count < QUEUE_DEPTH) begin
            mdl_sound[mdl_count]  = snd;
            mdl_volume[mdl_count] = vol;
            mdl_count++;
        end
    endfunction

    // Apply one accepted command; returns 0 when the block ignores it.
    function automatic bit predict_cmd(t_kind kind, logic [7:0] snd,
                                       logic [15:0] sx, logic [15:0] sy,
                                       logic [15:0] lx, logic [15:0] ly);
        int vol;
        case (kind)
            KIND_PLAY: begin
                if (!mdl_audio_on)
                    return 0;
                queue_sound(snd, VOL_MAX);
            end
            KIND_LOCATE: begin
                if (!mdl_audio_on)
                    return 0;
                vol = located_volume(sx, sy, lx, ly);
                if (vol < 0)
                    return 0;
                queue_sound(snd, 7'(vol));
            end
            KIND_DRAIN: begin
                for (int i = 0; i < mdl_count; i++)
                    drain_q.push_back('{mdl_sound[i], mdl_volume[i], i == mdl_count - 1});
                mdl_count = 0;
            end
            default: begin
                mdl_count = 0;
            end
        endcase
        return 1;
    endfunction

    function automatic logic [15:0] offset_coord(logic [15:0] base, int unsigned off);
        bit up_ok, down_ok;
        up_ok   = (base + off) <= 32'hFFFF;
        down_ok = base >= off;
        if (up_ok && (!down_ok || $urandom_range(0, 1) == 1))
            return 16'(base + off);
        if (down_ok)
            return 16'(base - off);
        return 16'd0;
    endfunction

    task automatic send_cmd(t_kind kind, logic [7:0] snd,
                            logic [15:0] sx, logic [15:0] sy,
                            logic [15:0] lx, logic [15:0] ly);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(1, 8);
        end
        burst_left--;
        start        <= 1'b1;
        i_kind       <= kind;
        i_sound_id   <= snd;
        i_source_x   <= sx;
        i_source_y   <= sy;
        i_listener_x <= lx;
        i_listener_y <= ly;
        do @(posedge i_clk); while (busy !== 1'b0);
        void'(predict_cmd(kind, snd, sx, sy, lx, ly));
        sent_items++;
    endtask

    // Hold the sender until every drain transfer has arrived.
    task automatic hold_for_results();
        start <= 1'b0;
        burst_left = 0;
        while (drain_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic quiesce();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [15:0] data);
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_AUDIO_ON)
            mdl_audio_on = data[0];
        else
            mdl_range = data;
    endtask

    task automatic send_random_located(logic [7:0] snd);
        int unsigned span, side;
        logic [15:0] sx, sy, lx, ly;
        lx = 16'($urandom);
        ly = 16'($urandom);
        case ($urandom_range(0, 4))
            0:       span = mdl_range;
            1:       span = mdl_range + 1 + $urandom_range(0, 3);
            default: span = $urandom_range(0, mdl_range);
        endcase
        if (span > 32'hFFFF)
            span = 32'hFFFF;
        side = $urandom_range(0, span);
        if ($urandom_range(0, 1) == 1) begin
            sx = offset_coord(lx, span);
            sy = offset_coord(ly, side);
        end else begin
            sx = offset_coord(lx, side);
            sy = offset_coord(ly, span);
        end
        send_cmd(KIND_LOCATE, snd, sx, sy, lx, ly);
    endtask

    task automatic test_audio_gate();
        // audio is off out of reset
        send_cmd(KIND_PLAY, 8'd7, 16'd0, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_LOCATE, 8'd8, 16'd10, 16'd10, 16'd10, 16'd10);
        send_cmd(KIND_DRAIN, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_cfg(CFG_AUDIO_ON, 16'd1);
        send_cmd(KIND_PLAY, 8'd5, 16'd0, 16'd0, 16'd0, 16'd0);
        // turning audio off keeps the queue
        write_cfg(CFG_AUDIO_ON, 16'd0);
        send_cmd(KIND_PLAY, 8'd6, 16'd0, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_DRAIN, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_cfg(CFG_AUDIO_ON, 16'hFFFF);
    endtask

    task automatic test_located_volume();
        send_cmd(KIND_LOCATE, 8'd1, 16'd0, 16'd3, 16'd525, 16'd0);
        send_cmd(KIND_LOCATE, 8'd2, 16'd100, 16'd626, 16'd100, 16'd100);
        send_cmd(KIND_LOCATE, 8'd1, 16'd1000, 16'd1000, 16'd1001, 16'd999);
        send_cmd(KIND_LOCATE, 8'd1, 16'd300, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_LOCATE, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(KIND_PLAY, 8'd4, 16'd0, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_LOCATE, 8'd255, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        send_cmd(KIND_DRAIN, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_PLAY, 8'd4, 16'd0, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_CLEAR, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_DRAIN, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    endtask

    task automatic test_range_extremes();
        write_cfg(CFG_RANGE, 16'd0);
        send_cmd(KIND_LOCATE, 8'd9, 16'd1234, 16'd4321, 16'd1234, 16'd4321);
        send_cmd(KIND_LOCATE, 8'd10, 16'd1234, 16'd4321, 16'd1235, 16'd4321);
        write_cfg(CFG_RANGE, 16'hFFFF);
        send_cmd(KIND_LOCATE, 8'd11, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        write_cfg(CFG_RANGE, 16'd1);
        send_cmd(KIND_LOCATE, 8'd12, 16'd5, 16'd5, 16'd6, 16'd4);
        send_cmd(KIND_LOCATE, 8'd13, 16'd5, 16'd5, 16'd5, 16'd7);
        send_cmd(KIND_DRAIN, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_cfg(CFG_RANGE, RANGE_RST);
    endtask

    task automatic test_queue_full();
        send_cmd(KIND_LOCATE, 8'd0, 16'd525, 16'd0, 16'd0, 16'd0);
        for (int i = 1; i < QUEUE_DEPTH; i++)
            send_cmd(KIND_PLAY, 8'(i * 17), 16'd0, 16'd0, 16'd0, 16'd0);
        // drop a new sound, still merge a queued one
        send_cmd(KIND_PLAY, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_PLAY, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_cmd(KIND_DRAIN, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    endtask

    task automatic change_settings();
        logic [15:0] rng;
        case ($urandom_range(0, 6))
            0:       rng = 16'd1;
            1:       rng = 16'hFFFF;
            2:       rng = RANGE_RST;
            3:       rng = 16'($urandom_range(2, 64));
            4:       rng = 16'($urandom_range(65, 4000));
            5:       rng = 16'($urandom);
            default: rng = 16'd0;
        endcase
        write_cfg(CFG_RANGE, rng);
        write_cfg(CFG_AUDIO_ON, {15'($urandom), 1'($urandom_range(0, 5) != 0)});
    endtask

    task automatic test_random_traffic();
        int pool_base, pool_size, n_req, pick;
        while (sent_items < TOTAL_ITEMS) begin
            if ($urandom_range(0, 5) == 0)
                change_settings();
            pool_base = $urandom_range(0, 255);
            // a wide pool with a long burst can overflow the queue
            pool_size = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                   : $urandom_range(1, 8);
            n_req = (pool_size > QUEUE_DEPTH) ? $urandom_range(16, 26)
                                              : $urandom_range(1, 10);
            repeat (n_req) begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    send_cmd(KIND_PLAY, 8'(pool_base + $urandom_range(0, pool_size - 1)),
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                else if (pick < 9)
                    send_random_located(8'(pool_base + $urandom_range(0, pool_size - 1)));
                else
                    send_cmd(t_kind'($urandom_range(0, 3)), 8'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                send_cmd(KIND_DRAIN, 8'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
                if ($urandom_range(0, 7) == 0)
                    hold_for_results();
            end else if (pick == 8) begin
                send_cmd(KIND_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Results cannot be held off: compare every transfer as it leaves.
    always @(posedge i_clk) begin
        t_drained exp_entry;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (drain_q.size() == 0) begin
                $error("unexpected result: out_sound %0d out_volume %0d last %0d",
                       o_out_sound, o_out_volume, o_last);
                n_fail++;
            end else begin
                exp_entry = drain_q.pop_front();
                if (o_out_sound !== exp_entry.snd) begin
                    $error("out_sound expected %0d got %0d", exp_entry.snd, o_out_sound);
                    n_fail++;
                end
                if (o_out_volume !== exp_entry.vol) begin
                    $error("out_volume expected %0d got %0d", exp_entry.vol, o_out_volume);
                    n_fail++;
                end
                if (o_last !== exp_entry.last) begin
                    $error("last expected %0d got %0d", exp_entry.last, o_last);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)
            || o_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_audio_gate();
        test_located_volume();
        test_range_extremes();
        test_queue_full();
        test_random_traffic();
        quiesce();
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* coalescing_sound_event_queue.f */
+incdir+sv
sv/csq_pkg.sv
sv/csq_ram.sv
sv/csq_vol.sv
sv/coalescing_sound_event_queue.sv
dv/coalescing_sound_event_queue_tb.sv
